// ===== rtl/bvss_pkg.sv =====
// Shared types and constants of the bounded value set store.
package bvss_pkg;

    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic               init;
        logic               seed;
        logic [VALUE_W-1:0] seed_val;
        logic [VALUE_W-1:0] key;
        logic               remove_mode;
        logic               step;
    } t_scan_ctl;

    // Running status of the scan unit.
    typedef struct packed {
        logic               matched;
        logic               have;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
    } t_scan_st;

endpackage

// ===== rtl/bvss_if.sv =====
// Channel interfaces for input words and result words.
interface bvss_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          op;
    logic signed [bvss_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bvss_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    found;
    logic [bvss_pkg::COUNT_OUT_W-1:0]        entry_count;
    logic                                    is_empty;
    logic signed [bvss_pkg::VALUE_W-1:0]     smallest;
    logic signed [bvss_pkg::VALUE_W-1:0]     largest;
    logic                                    overflow;

    modport source (output valid, output found, output entry_count, output is_empty,
                    output smallest, output largest, output overflow, input ready);
    modport sink   (input valid, input found, input entry_count, input is_empty,
                    input smallest, input largest, input overflow, output ready);
endinterface

// ===== rtl/bvss_mem.sv =====
// Entry memory: one write port and one registered read port.
module bvss_mem #(
    parameter int DEPTH = bvss_pkg::CAPACITY_DEF,
    parameter int AW    = 6
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [bvss_pkg::VALUE_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [bvss_pkg::VALUE_W-1:0] o_rd_data
);

    logic [bvss_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [bvss_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bvss_scan.sv =====
// Shared compare unit: equality match plus running minimum and maximum.
module bvss_scan (
    input  logic                         i_clk,
    input  bvss_pkg::t_scan_ctl          i_ctl,
    input  logic [bvss_pkg::VALUE_W-1:0] i_data,
    output bvss_pkg::t_scan_st           o_st,
    output logic                         o_skip
);

    bvss_pkg::t_scan_st r_st;
    logic               w_hit;
    logic               w_take;

    // The first equal entry of a remove is the deleted one and is left out.
    assign w_hit  = i_ctl.step && !r_st.matched && (i_data == i_ctl.key);
    assign o_skip = w_hit && i_ctl.remove_mode;
    assign w_take = i_ctl.step && !o_skip;

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_st.matched <= 1'b0;
            r_st.have    <= i_ctl.seed;
            r_st.lo      <= i_ctl.seed_val;
            r_st.hi      <= i_ctl.seed_val;
        end else begin
            if (w_hit) begin
                r_st.matched <= 1'b1;
            end
            if (w_take) begin
                r_st.have <= 1'b1;
                if (!r_st.have || ($signed(i_data) < $signed(r_st.lo))) begin
                    r_st.lo <= i_data;
                end
                if (!r_st.have || ($signed(r_st.hi) < $signed(i_data))) begin
                    r_st.hi <= i_data;
                end
            end
        end
    end

    assign o_st = r_st;

endmodule

// ===== rtl/bounded_value_set_store.sv =====
// Top level of the bounded value set store: sequencer, entry memory and scan unit.
//
// The input channel carries words of an operation (insert, remove, query) and a
// signed 32-bit value; the output channel returns one result word per input word
// with the found flag, entry count, empty flag, minimum, maximum and overflow flag.
// Entries live in a memory of CAPACITY words in insertion order.
// Every operation walks the held entries once through a single read port and one
// shared compare unit: the walk finds the first equal entry, moves later entries
// down one place on a remove, and tracks the minimum and maximum.
// An item therefore passes through these steps in order: acceptance, one read
// issued per held entry, the registered memory read, the scan unit register,
// and the load of the result register; on an empty store no entry is read.
// Ready is high only while the sequencer is idle. The result waits in an output
// register, so the next word is taken while the receiver stalls; the walk of that
// word then holds at its end until the previous result has been taken.
// Reset clears the entry count and the control state; the memory is not cleared,
// since only entries below the count are ever read.
module bounded_value_set_store #(
    parameter int CAPACITY = bvss_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bvss_in_if.sink           i_in,
    bvss_out_if.source        o_out
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int EXTW = CW + bvss_pkg::COUNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [1:0]                   r_op;
    logic [bvss_pkg::VALUE_W-1:0] r_val;
    logic                         r_ins_ok;
    logic                         r_ovf;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_iss;
    logic [CW-1:0]                r_lim;
    logic                         r_rv;
    logic [CW-1:0]                r_rpos;

    // Result register.
    logic                         r_o_valid;
    logic                         r_o_found;
    logic [bvss_pkg::COUNT_OUT_W-1:0] r_o_count;
    logic                         r_o_empty;
    logic [bvss_pkg::VALUE_W-1:0] r_o_lo;
    logic [bvss_pkg::VALUE_W-1:0] r_o_hi;
    logic                         r_o_ovf;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_issue;
    logic                         w_load;
    logic                         w_ins_wr;
    logic                         w_shift_wr;
    logic                         w_remove;
    logic                         w_found;
    logic [CW-1:0]                n_count;
    logic [EXTW-1:0]              w_count_ext;
    logic [CW-1:0]                w_shift_pos;
    logic                         w_mem_wr;
    logic [AW-1:0]                w_wr_addr;
    logic [bvss_pkg::VALUE_W-1:0] w_wr_data;
    logic [bvss_pkg::VALUE_W-1:0] w_rd_data;
    logic                         w_skip;

    bvss_pkg::t_scan_ctl          w_ctl;
    bvss_pkg::t_scan_st           w_st;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_ins_wr = w_accept && (i_in.op == bvss_pkg::OP_INSERT) && !w_full;
    assign w_issue  = (r_state == S_SCAN) && (r_iss != r_lim);
    assign w_load   = (r_state == S_DONE) && (!r_o_valid || o_out.ready);
    assign w_remove = (r_op == bvss_pkg::OP_REMOVE);

    // On a remove, every entry after the deleted one moves down one place.
    assign w_shift_wr  = r_rv && w_remove && w_st.matched;
    assign w_shift_pos = r_rpos - 1'b1;

    assign w_mem_wr  = w_ins_wr || w_shift_wr;
    assign w_wr_addr = w_ins_wr ? r_count[AW-1:0] : w_shift_pos[AW-1:0];
    assign w_wr_data = w_ins_wr ? i_in.value : w_rd_data;

    // A successful insert seeds the minimum and maximum with the new value,
    // so the walk covers only the entries held before it.
    always_comb begin
        w_ctl.init        = w_accept;
        w_ctl.seed        = w_ins_wr;
        w_ctl.seed_val    = i_in.value;
        w_ctl.key         = r_val;
        w_ctl.remove_mode = w_remove;
        w_ctl.step        = r_rv;
    end

    always_comb begin
        case (r_op)
            bvss_pkg::OP_INSERT: begin
                w_found = r_ins_ok;
                n_count = r_ins_ok ? (r_count + 1'b1) : r_count;
            end
            bvss_pkg::OP_REMOVE: begin
                w_found = w_st.matched;
                n_count = w_st.matched ? (r_count - 1'b1) : r_count;
            end
            bvss_pkg::OP_QUERY: begin
                w_found = w_st.matched;
                n_count = r_count;
            end
            default: begin
                w_found = 1'b0;
                n_count = r_count;
            end
        endcase
    end

    assign w_count_ext = EXTW'(n_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_issue && !r_rv) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= w_issue;
            if (w_load) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end

        if (w_accept) begin
            r_op     <= i_in.op;
            r_val    <= i_in.value;
            r_ins_ok <= w_ins_wr;
            r_ovf    <= (i_in.op == bvss_pkg::OP_INSERT) && w_full;
            r_iss    <= '0;
            r_lim    <= r_count;
        end else if (w_issue) begin
            r_iss <= r_iss + 1'b1;
        end
        r_rpos <= r_iss;

        if (w_load) begin
            r_o_found <= w_found;
            r_o_count <= w_count_ext[bvss_pkg::COUNT_OUT_W-1:0];
            r_o_empty <= (n_count == '0);
            r_o_lo    <= w_st.have ? w_st.lo : '0;
            r_o_hi    <= w_st.have ? w_st.hi : '0;
            r_o_ovf   <= r_ovf;
        end
    end

    bvss_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_iss[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    bvss_scan u_scan (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_data (w_rd_data),
        .o_st   (w_st),
        .o_skip (w_skip)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_o_valid;
    assign o_out.found       = r_o_found;
    assign o_out.entry_count = r_o_count;
    assign o_out.is_empty    = r_o_empty;
    assign o_out.smallest    = r_o_lo;
    assign o_out.largest     = r_o_hi;
    assign o_out.overflow    = r_o_ovf;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_only_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift_wr |-> (r_op == bvss_pkg::OP_REMOVE) && !w_ins_wr)
        else $error("entry move outside a remove");

    a_skip_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_skip |=> !w_skip)
        else $error("more than one entry deleted in one remove");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_state != S_DONE) |=> $stable(r_count))
        else $error("entry count changed outside result load");

    a_empty_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_empty |-> (r_o_lo == '0) && (r_o_hi == '0))
        else $error("empty store reports nonzero bounds");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the bounded value set store: scoreboard, drivers and checks.

// Field widths used by the checks.
typedef logic [bvss_pkg::VALUE_W-1:0]     t_field;
typedef logic [bvss_pkg::COUNT_OUT_W-1:0] t_count;

// One result word as the block should deliver it.
typedef struct packed {
    logic                                found;
    logic [bvss_pkg::COUNT_OUT_W-1:0]    entry_count;
    logic                                is_empty;
    logic signed [bvss_pkg::VALUE_W-1:0] smallest;
    logic signed [bvss_pkg::VALUE_W-1:0] largest;
    logic                                overflow;
} t_store_result;

// Keeps its own copy of the held entries and predicts one result per accepted word.
class set_scoreboard;
    int unsigned                         capacity;
    logic signed [bvss_pkg::VALUE_W-1:0] held[$];
    t_store_result                       pending[$];
    int unsigned                         errors;
    int unsigned                         checked;
    int unsigned                         overflows;
    int unsigned                         remove_hits;
    int unsigned                         query_hits;
    int unsigned                         peak;

    function new(int unsigned cap);
        capacity    = cap;
        errors      = 0;
        checked     = 0;
        overflows   = 0;
        remove_hits = 0;
        query_hits  = 0;
        peak        = 0;
    endfunction

    // Applies an accepted word to the shadow store and queues the result it must cause.
    function void note_word(logic [1:0] op, logic signed [bvss_pkg::VALUE_W-1:0] v);
        t_store_result want;
        int            idx;
        want = '0;
        idx  = -1;
        for (int i = 0; i < held.size(); i++) begin
            if (idx < 0 && held[i] == v) begin
                idx = i;
            end
        end
        case (op)
            bvss_pkg::OP_INSERT: begin
                if (held.size() < capacity) begin
                    held.push_back(v);
                    want.found = 1'b1;
                end else begin
                    want.overflow = 1'b1;
                    overflows++;
                end
            end
            bvss_pkg::OP_REMOVE: begin
                // Only the first equal entry goes; later entries move down one place.
                if (idx >= 0) begin
                    held.delete(idx);
                    want.found = 1'b1;
                    remove_hits++;
                end
            end
            bvss_pkg::OP_QUERY: begin
                want.found = (idx >= 0);
                if (idx >= 0) begin
                    query_hits++;
                end
            end
            default: begin
            end
        endcase
        want.entry_count = t_count'(held.size());
        want.is_empty    = (held.size() == 0);
        if (held.size() > 0) begin
            want.smallest = held[0];
            want.largest  = held[0];
            foreach (held[i]) begin
                if (held[i] < want.smallest) want.smallest = held[i];
                if (held[i] > want.largest)  want.largest  = held[i];
            end
        end
        if (held.size() > peak) peak = held.size();
        pending.push_back(want);
    endfunction

    function void compare_field(string name, t_field want, t_field got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compares an accepted result word with the oldest prediction.
    function void check_result(t_store_result got);
        t_store_result want;
        if (pending.size() == 0) begin
            $display("%0t: result word with no word outstanding, expected none, actual %0h",
                     $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        compare_field("found",       t_field'(want.found),       t_field'(got.found));
        compare_field("entry_count", t_field'(want.entry_count), t_field'(got.entry_count));
        compare_field("is_empty",    t_field'(want.is_empty),    t_field'(got.is_empty));
        compare_field("smallest",    t_field'(want.smallest),    t_field'(got.smallest));
        compare_field("largest",     t_field'(want.largest),     t_field'(got.largest));
        compare_field("overflow",    t_field'(want.overflow),    t_field'(got.overflow));
        checked++;
    endfunction
endclass

module tb_top;

    localparam int         CAPACITY     = bvss_pkg::CAPACITY_DEF;
    localparam int         RANDOM_ITEMS = 2000;
    localparam int         IDLE_LIMIT   = 4000;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic signed [bvss_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [bvss_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    bvss_in_if  in_if();
    bvss_out_if out_if();

    bounded_value_set_store #(.CAPACITY(CAPACITY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    set_scoreboard sb = new(CAPACITY);

    int unsigned words_sent = 0;
    int unsigned burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Holds valid until the word is taken, then records it with the scoreboard.
    task automatic send_word(input logic [1:0] op,
                             input logic signed [bvss_pkg::VALUE_W-1:0] v);
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= v;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_word(op, v);
        words_sent++;
    endtask

    // Sends one word inside the current burst; at the end of a burst the sender may pause.
    task automatic issue_word(input logic [1:0] op,
                              input logic signed [bvss_pkg::VALUE_W-1:0] v);
        int unsigned gap;
        send_word(op, v);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 3);
                2:       gap = $urandom_range(4, 20);
                default: gap = $urandom_range(21, 70);
            endcase
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Extremes and a few small values, so that duplicates and hits are frequent.
    function automatic logic signed [bvss_pkg::VALUE_W-1:0] pool_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return int'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    function automatic logic signed [bvss_pkg::VALUE_W-1:0] pick_value(input logic [1:0] op);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (op == bvss_pkg::OP_INSERT) begin
            if (roll < 40) return pool_value();
            if (roll < 60 && sb.held.size() > 0)
                return sb.held[$urandom_range(0, sb.held.size() - 1)];
            return $urandom;
        end
        if (roll < 55 && sb.held.size() > 0)
            return sb.held[$urandom_range(0, sb.held.size() - 1)];
        if (roll < 75) return pool_value();
        return $urandom;
    endfunction

    // Receiver: ready follows a randomly chosen stall mode: always ready, short stalls, long stalls, or a bit pattern.
    initial begin
        int unsigned  cyc;
        int unsigned  mode;
        int unsigned  stall;
        logic [7:0]   pattern;
        cyc     = 0;
        mode    = 0;
        stall   = 0;
        pattern = 8'hFF;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                sb.check_result('{found:       out_if.found,
                                  entry_count: out_if.entry_count,
                                  is_empty:    out_if.is_empty,
                                  smallest:    out_if.smallest,
                                  largest:     out_if.largest,
                                  overflow:    out_if.overflow});
            end
            cyc++;
            if (cyc % 256 == 0) begin
                mode    = $urandom_range(0, 3);
                pattern = 8'($urandom_range(1, 255));
            end
            case (mode)
                0: out_if.ready <= 1'b1;
                3: out_if.ready <= pattern[cyc % 8];
                default: begin
                    if (stall > 0) begin
                        stall--;
                        out_if.ready <= 1'b0;
                    end else begin
                        out_if.ready <= 1'b1;
                        if (mode == 1 && $urandom_range(0, 99) < 30)
                            stall = $urandom_range(1, 3);
                        else if (mode == 2 && $urandom_range(0, 99) < 10)
                            stall = $urandom_range(10, 48);
                    end
                end
            endcase
        end
    end

    // Watchdog: too many cycles without any word moving on either channel ends the run.
    initial begin
        int unsigned idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                         $time, idle, sb.pending.size());
                $display("FAIL bounded_value_set_store");
                $finish;
            end
        end
    end

    // Stimulus: a directed opening, then random phases that fill, drain or mix the store.
    initial begin
        int unsigned rnd_sent;
        int unsigned phase_kind;
        int unsigned phase_len;
        int unsigned roll;
        logic [1:0]  op;
        logic signed [bvss_pkg::VALUE_W-1:0] v;

        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.op    <= bvss_pkg::OP_INSERT;
        in_if.value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 12);

        // Empty store: misses, a no-op opcode, and zero minimum and maximum.
        issue_word(bvss_pkg::OP_QUERY,  0);
        issue_word(bvss_pkg::OP_REMOVE, 5);
        issue_word(OP_UNUSED, VAL_MAX);
        // Extremes of the value range set the minimum and maximum.
        issue_word(bvss_pkg::OP_INSERT, VAL_MAX);
        issue_word(bvss_pkg::OP_INSERT, VAL_MIN);
        issue_word(bvss_pkg::OP_INSERT, 0);
        issue_word(bvss_pkg::OP_INSERT, -1);
        // A duplicate is stored; removing it takes the first copy only.
        issue_word(bvss_pkg::OP_INSERT, 7);
        issue_word(bvss_pkg::OP_INSERT, 7);
        issue_word(bvss_pkg::OP_QUERY,  7);
        issue_word(bvss_pkg::OP_QUERY,  8);
        issue_word(bvss_pkg::OP_REMOVE, 7);
        issue_word(bvss_pkg::OP_QUERY,  7);
        issue_word(bvss_pkg::OP_REMOVE, 7);
        issue_word(bvss_pkg::OP_REMOVE, 7);
        issue_word(OP_UNUSED, 0);
        // Removing the extremes from the front moves the rest down.
        issue_word(bvss_pkg::OP_REMOVE, VAL_MAX);
        issue_word(bvss_pkg::OP_REMOVE, VAL_MIN);
        issue_word(bvss_pkg::OP_INSERT, 32'sh5555_5555);
        issue_word(bvss_pkg::OP_INSERT, 32'shAAAA_AAAA);
        issue_word(bvss_pkg::OP_REMOVE, 0);
        issue_word(bvss_pkg::OP_REMOVE, -1);
        issue_word(bvss_pkg::OP_REMOVE, 32'sh5555_5555);
        issue_word(bvss_pkg::OP_REMOVE, 32'shAAAA_AAAA);
        issue_word(bvss_pkg::OP_QUERY,  32'shAAAA_AAAA);

        // Fill phases reach the full store and its dropped inserts; drain phases empty it.
        rnd_sent = 0;
        while (rnd_sent < RANDOM_ITEMS) begin
            phase_kind = $urandom_range(0, 2);
            phase_len  = $urandom_range(40, 200);
            for (int k = 0; k < phase_len && rnd_sent < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0:       op = (roll < 80) ? bvss_pkg::OP_INSERT :
                                  (roll < 90) ? bvss_pkg::OP_REMOVE :
                                  (roll < 98) ? bvss_pkg::OP_QUERY  : OP_UNUSED;
                    1:       op = (roll < 15) ? bvss_pkg::OP_INSERT :
                                  (roll < 80) ? bvss_pkg::OP_REMOVE :
                                  (roll < 98) ? bvss_pkg::OP_QUERY  : OP_UNUSED;
                    default: op = (roll < 40) ? bvss_pkg::OP_INSERT :
                                  (roll < 70) ? bvss_pkg::OP_REMOVE :
                                  (roll < 98) ? bvss_pkg::OP_QUERY  : OP_UNUSED;
                endcase
                v = pick_value(op);
                issue_word(op, v);
                rnd_sent++;
            end
        end
        in_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        // Let any stray result word show up before the verdict.
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("Covered %0d words, %0d results checked, peak occupancy %0d of %0d.",
                 words_sent, sb.checked, sb.peak, CAPACITY);
        $display("Dropped inserts %0d, removes that hit %0d, queries that hit %0d.",
                 sb.overflows, sb.remove_hits, sb.query_hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS bounded_value_set_store");
        end else begin
            $display("FAIL bounded_value_set_store");
        end
        $finish;
    end

endmodule
